@@ hw/rtl/lkvc_pkg.sv @@
// lkvc_pkg: shared constants, types and control structs for the LRU key-value cache.
// No dependencies; imported by every module of the cache.

package lkvc_pkg;

  // Store geometry and field widths
  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Update applied to the chain of cells in the update cycle
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_EVICT,
    UPD_FILL
  } lkvc_upd_t;

  // Request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lkvc_state_t;

  // One entry as it moves from cell to cell
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             valid;
  } lkvc_entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             cmp_en;
    lkvc_upd_t        upd;
    logic [KEY_W-1:0] req_key;
    logic [VAL_W-1:0] ins_value;
  } lkvc_ctrl_t;

  // Lookup status gathered from the cells
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] hit_value;
    logic [KEY_W-1:0] tail_key;
  } lkvc_stat_t;

endpackage

@@ hw/rtl/lkvc_cell.sv @@
// lkvc_cell: one slot of the recency-ordered chain; holds a key, a value and a valid bit.
// Depends on lkvc_pkg. Cell 0 is the most recent entry, the last valid cell the least recent.

module lkvc_cell
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lkvc_ctrl_t       ctrl,
  input  lkvc_entry_t      prev_entry,  // entry of the more recent neighbour
  input  logic             hit_below,   // a match sits in some less recent cell
  input  logic             next_valid,  // valid bit of the less recent neighbour
  output lkvc_entry_t      entry,
  output logic             hit_chain,   // a match sits in this cell or below
  output logic             match,
  output logic [VAL_W-1:0] hit_value,
  output logic [KEY_W-1:0] tail_key
);

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             valid_r;
  logic             match_r;
  logic             shift;

  assign entry     = '{key: key_r, value: value_r, valid: valid_r};
  assign match     = match_r;
  assign hit_chain = match_r | hit_below;
  assign hit_value = match_r ? value_r : '0;
  assign tail_key  = (valid_r && !next_valid) ? key_r : '0;

  // Decide whether this cell takes its neighbour's entry
  always_comb begin
    unique case (ctrl.upd)
      UPD_HIT:   shift = hit_chain;
      UPD_EVICT: shift = valid_r;
      UPD_FILL:  shift = prev_entry.valid;
      UPD_NONE:  shift = 1'b0;
      default:   shift = 1'b0;
    endcase
  end

  // Hold the compare result and the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        match_r <= valid_r && (key_r == ctrl.req_key);
      end
      if (shift) begin
        valid_r <= prev_entry.valid;
      end
    end
  end

  // Advance the payload down the chain
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev_entry.key;
      value_r <= prev_entry.value;
    end
  end

endmodule

@@ hw/rtl/lkvc_ctrl.sv @@
// lkvc_ctrl: request sequencer, capacity register, occupancy count and result register.
// Depends on lkvc_pkg; drives the cell chain through lkvc_ctrl_t and reads lkvc_stat_t.

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CAP_W-1:0]      cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [KEY_W+VAL_W-1:0] in_tdata,   // lookup_key, write_value
  input  logic [0:0]            in_tuser,    // req_type (0 get, 1 put)
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VAL_W+KEY_W-1:0] out_tdata,  // read_value, evicted_key
  output logic [1:0]            out_tuser,   // hit, evicted
  output lkvc_ctrl_t            ctrl,
  input  lkvc_stat_t            stat
);

  lkvc_state_t      state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [OCC_W-1:0] occ_r;
  logic             req_put_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_val_r;
  logic             out_valid_r;
  logic             out_hit_r, out_ev_r;
  logic [VAL_W-1:0] out_rd_r;
  logic [KEY_W-1:0] out_evk_r;

  logic             out_free;
  logic             upd_go;
  logic             occ_full;
  logic [CMP_W-1:0] cap_ext, eff_cap;
  lkvc_upd_t        kind_sel;
  logic [VAL_W-1:0] rd_sel;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_MATCH;
      ST_MATCH:  state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    upd_go    = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_MATCH:  ;
      ST_UPDATE: upd_go = out_free;
      default:   ;
    endcase
  end

  // Clamp the capacity to 1..DEPTH
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign occ_full = CMP_W'(occ_r) >= eff_cap;

  // Pick the chain update for the pending transaction
  always_comb begin
    priority if (stat.hit) begin
      kind_sel = UPD_HIT;
    end else if (!req_put_r) begin
      kind_sel = UPD_NONE;
    end else if (occ_full) begin
      kind_sel = UPD_EVICT;
    end else begin
      kind_sel = UPD_FILL;
    end
  end

  always_comb begin
    priority if (req_put_r) begin
      rd_sel = '0;
    end else if (stat.hit) begin
      rd_sel = stat.hit_value;
    end else begin
      rd_sel = '1;
    end
  end

  assign ctrl = '{
    cmp_en:    (state_r == ST_MATCH),
    upd:       upd_go ? kind_sel : UPD_NONE,
    req_key:   req_key_r,
    ins_value: req_put_r ? req_val_r : stat.hit_value
  };

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (upd_go && kind_sel == UPD_FILL) begin
        occ_r <= occ_r + OCC_W'(1);
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and the result
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_put_r <= in_tuser[0];
      req_key_r <= in_tdata[KEY_W-1:0];
      req_val_r <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (upd_go) begin
      out_hit_r <= stat.hit;
      out_rd_r  <= rd_sel;
      out_ev_r  <= (kind_sel == UPD_EVICT);
      out_evk_r <= (kind_sel == UPD_EVICT) ? stat.tail_key : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_evk_r, out_rd_r};
  assign out_tuser  = {out_ev_r, out_hit_r};

  // Occupancy never passes the store depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(occ_r) <= CMP_W'(DEPTH))
    else $error("occupancy above depth");

  // An eviction needs at least one held entry
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.upd == UPD_EVICT |-> occ_r != '0)
    else $error("eviction from an empty store");

  // A fill only while below the capacity
  a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.upd == UPD_FILL |-> !occ_full && !stat.hit)
    else $error("fill without room");

  // Every update loads a result onto the output and returns the sequencer to idle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_tvalid && state_r == ST_IDLE)
    else $error("result not presented after update");

endmodule

@@ hw/rtl/lru_key_value_cache_top.sv @@
// lru_key_value_cache_top: top level of the LRU key-value cache.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_cell; builds a chain of DEPTH cells.

// A request passes in order through accept, match and update: the transaction is accepted,
// every cell of the chain compares its key with the request key, and the chain shifts to put
// the touched entry at the front while the result is loaded into the output register. The update
// cycle waits while an earlier result is still held on the output. Entries are kept in recency
// order, cell 0 the most recent, so a hit or an insertion moves the more recent cells one step
// down and the least recent valid cell supplies the evicted key. The capacity register resets
// to 16; values 0 and above the store depth act as 1 and the depth.

module lru_key_value_cache_top
  import lkvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data,   // capacity
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W+VAL_W-1:0] in_tdata,      // lookup_key, write_value
  input  logic [0:0]             in_tuser,      // req_type (0 get, 1 put)
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [VAL_W+KEY_W-1:0] out_tdata,     // read_value, evicted_key
  output logic [1:0]             out_tuser      // hit, evicted
);

  lkvc_ctrl_t       ctrl;
  lkvc_stat_t       stat;
  lkvc_entry_t      head_entry;
  lkvc_entry_t      cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_hit_chain;
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] cell_valid;
  logic [VAL_W-1:0] cell_hit_value [DEPTH];
  logic [KEY_W-1:0] cell_tail_key [DEPTH];
  logic [VAL_W-1:0] hit_value_or;
  logic [KEY_W-1:0] tail_key_or;

  lkvc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .ctrl        (ctrl),
    .stat        (stat)
  );

  // New entry enters at the front of the chain
  assign head_entry = '{key: ctrl.req_key, value: ctrl.ins_value, valid: 1'b1};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lkvc_entry_t prev_in;
    logic        below_hit;
    logic        below_valid;

    if (i == 0) begin : g_first
      assign prev_in = head_entry;
    end else begin : g_inner
      assign prev_in = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below_hit   = 1'b0;
      assign below_valid = 1'b0;
    end else begin : g_body
      assign below_hit   = cell_hit_chain[i+1];
      assign below_valid = cell_entry[i+1].valid;
    end

    lkvc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_entry (prev_in),
      .hit_below  (below_hit),
      .next_valid (below_valid),
      .entry      (cell_entry[i]),
      .hit_chain  (cell_hit_chain[i]),
      .match      (cell_match[i]),
      .hit_value  (cell_hit_value[i]),
      .tail_key   (cell_tail_key[i])
    );

    assign cell_valid[i] = cell_entry[i].valid;
  end

  // Gather the matching value and the least recent key
  always_comb begin
    hit_value_or = '0;
    tail_key_or  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_value_or = hit_value_or | cell_hit_value[i];
      tail_key_or  = tail_key_or | cell_tail_key[i];
    end
  end

  assign stat = '{hit: cell_hit_chain[0], hit_value: hit_value_or, tail_key: tail_key_or};

  // Keys held in the chain are unique, so at most one cell matches
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_match))
    else $error("more than one cell matches");

  // Valid entries fill the chain from the front without gaps
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + DEPTH'(1))) == '0)
    else $error("gap in the valid entries");

  // A hit always comes from a valid cell
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_match & ~cell_valid) == '0 || ctrl.upd == UPD_NONE)
    else $error("match on an invalid cell");

endmodule
